@@ sv/pps_pkg.sv @@
`timescale 1ns / 1ps

package pps_pkg;

    localparam int TIME_W = 24;
    localparam int ID_W   = 5;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [BUR_W-1:0] remaining;
        logic [PRI_W-1:0] priority_level;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_APPLY,
        ST_FINISH
    } state_t;

endpackage

@@ sv/pps_table.sv @@
`timescale 1ns / 1ps

module pps_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  pps_pkg::entry_t  wr_entry,
    input  logic [AW-1:0]    rd_addr,
    output pps_pkg::entry_t  rd_entry
);
    import pps_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

@@ sv/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// Preemptive priority scheduler.
// Slave stream s_axis carries one command item: tuser = command (0 load, 1 tick),
// tdata = arrival_time, burst_time, priority_level from bit 0 up (5 bytes).
// A load writes the next free table slot and gives no result; loads
// into a full table are dropped. A tick scans the table one entry per cycle
// through the single read port of the entry memory, picks the eligible entry with
// the smallest priority (lowest slot on a tie), serves it one time unit and emits
// one result item on m_axis: tuser = finished, tdata = tick_end_time, running_id,
// completion_time, turnaround_time, waiting_time from bit 0 up (13 bytes).
// A tick steps through ST_SCAN, ST_FETCH, ST_APPLY and ST_FINISH, which loads
// the result register once it is free; the next item is taken in ST_IDLE, where
// loads are written as taken. s_axis_tready is high only while no tick is in work.
// The result register holds while m_axis_tready is low; a new item may be
// accepted meanwhile, but the next tick result waits until the register frees.
// Reset clears the table fill count, done flags, time and the result valid flag;
// the entry memory itself is not cleared (only loaded slots are ever used).

module preemptive_priority_scheduler #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // arrival_time, burst_time, priority_level
    input  logic         s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // tick_end_time, running_id, completion_time,
                                        // turnaround_time, waiting_time, pad
    output logic         m_axis_tuser   // finished
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [TIME_W-1:0]        time_reg, time_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic                     sel_reg, sel_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [PRI_W-1:0]         best_prio_reg, best_prio_next;
    logic                     fin_reg, fin_next;
    logic [TIME_W-1:0]        tat_reg, tat_next;
    logic [BUR_W-1:0]         burst_reg, burst_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic                     m_valid_reg, m_valid_next;
    logic [103:0]             m_data_reg, m_data_next;
    logic                     m_fin_reg, m_fin_next;

    logic             s_accept;
    logic             scan_done;
    logic             out_free;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_entry;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_entry;

    logic [ARR_W-1:0] in_arrival;
    logic [BUR_W-1:0] in_burst;
    logic [PRI_W-1:0] in_prio;

    logic              elig;
    logic [BUR_W-1:0]  rem_dec;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] wt;
    logic [TIME_W-1:0] ct_out;
    logic [TIME_W-1:0] tat_out;

    assign in_arrival = s_axis_tdata[15:0];
    assign in_burst   = s_axis_tdata[31:16];
    assign in_prio    = s_axis_tdata[39:32];

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign scan_done = (issue_reg == count_reg) && !pend_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;

    pps_table #(
        .DEPTH (MAX_PROCESSES),
        .AW    (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_entry (mem_wr_entry),
        .rd_addr  (mem_rd_addr),
        .rd_entry (mem_rd_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_axis_tuser == CMD_TICK)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = count_reg[IDX_W-1:0];
        mem_wr_entry  = '{arrival: in_arrival, burst: in_burst, remaining: in_burst,
                          priority_level: in_prio};
        mem_rd_addr   = issue_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mem_wr_en     = s_axis_tvalid && s_axis_tuser == CMD_LOAD &&
                                count_reg < CNT_W'(MAX_PROCESSES);
            end
            ST_SCAN:  mem_rd_addr = issue_reg[IDX_W-1:0];
            ST_FETCH: mem_rd_addr = best_idx_reg;
            ST_APPLY:
            begin
                mem_wr_en    = sel_reg;
                mem_wr_addr  = best_idx_reg;
                mem_wr_entry = mem_rd_entry;
                mem_wr_entry.remaining = rem_dec;
            end
            ST_FINISH: ;
            default: ;
        endcase
    end

    assign elig     = pend_reg && !done_reg[pend_idx_reg] &&
                      ({{(TIME_W-ARR_W){1'b0}}, mem_rd_entry.arrival} <= time_reg);
    assign rem_dec  = mem_rd_entry.remaining - BUR_W'(1);
    assign time_inc = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
    assign wt       = (tat_reg >= {{(TIME_W-BUR_W){1'b0}}, burst_reg}) ?
                      tat_reg - {{(TIME_W-BUR_W){1'b0}}, burst_reg} : '0;
    assign ct_out   = fin_reg ? time_reg : '0;
    assign tat_out  = fin_reg ? tat_reg : '0;

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        time_next      = time_reg;
        done_next      = done_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        sel_next       = sel_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        fin_next       = fin_reg;
        tat_next       = tat_reg;
        burst_next     = burst_reg;
        id_next        = id_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_fin_next     = m_fin_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (mem_wr_en)
                begin
                    done_next[count_reg[IDX_W-1:0]] = (in_burst == '0);
                    count_next = count_reg + CNT_W'(1);
                end
                issue_next = '0;
                pend_next  = 1'b0;
                sel_next   = 1'b0;
            end
            ST_SCAN:
            begin
                if (issue_reg != count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (elig && (!sel_reg || mem_rd_entry.priority_level < best_prio_reg))
                begin
                    sel_next       = 1'b1;
                    best_idx_next  = pend_idx_reg;
                    best_prio_next = mem_rd_entry.priority_level;
                end
            end
            ST_FETCH: ;
            ST_APPLY:
            begin
                time_next  = time_inc;
                fin_next   = sel_reg && (rem_dec == '0);
                tat_next   = time_inc - {{(TIME_W-ARR_W){1'b0}}, mem_rd_entry.arrival};
                burst_next = mem_rd_entry.burst;
                id_next    = sel_reg ? ID_W'(32'(best_idx_reg) + 32'd1) : '0;
                if (sel_reg && rem_dec == '0)
                begin
                    done_next[best_idx_reg] = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_fin_next   = fin_reg;
                    m_data_next  = {3'b000, (fin_reg ? wt : '0), tat_out, ct_out,
                                    id_reg, time_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            time_reg    <= '0;
            done_reg    <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            done_reg    <= done_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        fin_reg       <= fin_next;
        tat_reg       <= tat_next;
        burst_reg     <= burst_next;
        id_reg        <= id_next;
        m_data_reg    <= m_data_next;
        m_fin_reg     <= m_fin_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_fin_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCESSES))
        else $error("entry count beyond table depth");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[100:29] == '0))
        else $error("time fields set on a result without completion");

    a_fin_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[28:24] != '0 ||
                                             MAX_PROCESSES > 31))
        else $error("completion reported on an idle tick");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> m_axis_tvalid)
        else $error("tick finished without a result");

endmodule

@@ verif/preemptive_priority_scheduler_test.sv @@
`timescale 1ns / 1ps

module preemptive_priority_scheduler_test;

    import pps_pkg::*;

    localparam int SLOTS       = 16;
    localparam int TICK_TARGET = 1060;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_LEN    = 600;

    typedef struct packed {
        logic             cmd;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        logic [PRI_W-1:0] pri;
    } sched_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] end_time;
        logic [ID_W-1:0]   id;
        logic              fin;
        logic [TIME_W-1:0] ct;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
    } tick_report_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;

    preemptive_priority_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // scheduler shadow state
    logic [ARR_W-1:0]  arr_tab [SLOTS];
    logic [BUR_W-1:0]  bur_tab [SLOTS];
    logic [BUR_W-1:0]  rem_tab [SLOTS];
    logic [PRI_W-1:0]  pri_tab [SLOTS];
    logic [SLOTS-1:0]  done_tab = '0;
    int                n_loaded = 0;
    logic [TIME_W-1:0] clock_now = '0;

    sched_cmd_t   pending_cmds [$];
    tick_report_t tick_results [$];

    int errors = 0;
    int items_taken = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int idle_ticks = 0;
    int completions = 0;
    int dropped_loads = 0;
    logic in_taken = 1'b0;

    function automatic void add_load(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                                     input logic [PRI_W-1:0] pri);
        pending_cmds.push_back({CMD_LOAD, arr, bur, pri});
    endfunction

    // tick fields other than the command are don't-care, so randomize them
    function automatic void add_tick();
        pending_cmds.push_back({CMD_TICK, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom)});
    endfunction

    function automatic void schedule_step(input sched_cmd_t c);
        tick_report_t r;
        int sel;
        logic [TIME_W-1:0] tat;
        if (c.cmd == CMD_LOAD)
        begin
            if (n_loaded < SLOTS)
            begin
                arr_tab[n_loaded]  = c.arr;
                bur_tab[n_loaded]  = c.bur;
                rem_tab[n_loaded]  = c.bur;
                pri_tab[n_loaded]  = c.pri;
                done_tab[n_loaded] = (c.bur == '0);
                n_loaded++;
            end
            else
            begin
                dropped_loads++;
            end
            return;
        end
        sel = -1;
        for (int i = 0; i < n_loaded; i++)
        begin
            if (!done_tab[i] && TIME_W'(arr_tab[i]) <= clock_now)
            begin
                if (sel < 0 || pri_tab[i] < pri_tab[sel])
                    sel = i;
            end
        end
        if (clock_now != TIME_MAX)
            clock_now = clock_now + 1'b1;
        r = '0;
        r.end_time = clock_now;
        if (sel < 0)
        begin
            idle_ticks++;
        end
        else
        begin
            r.id = ID_W'(sel + 1);
            rem_tab[sel] = rem_tab[sel] - 1'b1;
            if (rem_tab[sel] == '0)
            begin
                done_tab[sel] = 1'b1;
                completions++;
                tat   = clock_now - TIME_W'(arr_tab[sel]);
                r.fin = 1'b1;
                r.ct  = clock_now;
                r.tat = tat;
                r.wt  = (tat >= TIME_W'(bur_tab[sel])) ? tat - TIME_W'(bur_tab[sel]) : '0;
            end
        end
        tick_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("  result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        sched_cmd_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!(s_axis_tvalid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                s_axis_tdata  <= {c.pri, c.bur, c.arr};
                s_axis_tuser  <= c.cmd;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: phases of free flow and random stalls, plus one long hold-off
    int hold_left = 0;
    logic hold_done = 1'b0;
    int phase_left = 0;
    logic stall_phase = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_phase = ($urandom_range(0, 2) != 0);
                phase_left  = $urandom_range(20, 200);
            end
            else
            begin
                phase_left--;
            end
            if (stall_phase)
                m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tick_report_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items taken", cycle_count, items_taken);
            $display("preemptive_priority_scheduler: mismatch");
            $finish;
        end
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (tick_results.size() == 0)
                begin
                    report_mismatch("unexpected item, running_id", 32'(m_axis_tdata[28:24]), 0);
                end
                else
                begin
                    want = tick_results.pop_front();
                    check_field("tick_end_time", 32'(m_axis_tdata[23:0]), 32'(want.end_time));
                    check_field("running_id", 32'(m_axis_tdata[28:24]), 32'(want.id));
                    check_field("finished", 32'(m_axis_tuser), 32'(want.fin));
                    check_field("completion_time", 32'(m_axis_tdata[52:29]), 32'(want.ct));
                    check_field("turnaround_time", 32'(m_axis_tdata[76:53]), 32'(want.tat));
                    check_field("waiting_time", 32'(m_axis_tdata[100:77]), 32'(want.wt));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_taken++;
                schedule_step({s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                               s_axis_tdata[39:32]});
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    initial
    begin
        int n_ticks;
        int total_items;
        int k;
        // directed table: extremes, zero burst, priority tie, never-arriving entry,
        // long low-priority background job
        add_load(16'd0, 16'd1, 8'd0);
        add_load(16'd0, 16'd0, 8'd0);
        add_load(16'hFFFF, 16'hFFFF, 8'hFF);
        add_load(16'd5, 16'hFFFF, 8'hFF);
        add_load(16'd3, 16'd3, 8'd7);
        add_load(16'd3, 16'd2, 8'd7);
        for (k = 0; k < SLOTS - 6; k++)
            add_load(ARR_W'($urandom_range(0, 600)), BUR_W'($urandom_range(1, 30)),
                     PRI_W'($urandom_range(0, 255)));
        // table full: these are dropped
        add_load(16'd0, 16'd1, 8'd0);
        add_load(ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
        repeat (5) add_tick();
        n_ticks = 0;
        while (n_ticks < TICK_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_load(ARR_W'($urandom), BUR_W'($urandom_range(0, 65535)), PRI_W'($urandom));
            end
            else
            begin
                add_tick();
                n_ticks++;
            end
        end
        total_items = pending_cmds.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items)
            @(posedge clk);
        while (tick_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d items: %0d ticks (%0d idle, %0d completions), %0d loads dropped",
                 items_taken, results_seen, idle_ticks, completions, dropped_loads);
        $display("one receiver hold-off of %0d cycles, %0d cycles total", HOLD_LEN, cycle_count);
        if (errors == 0)
            $display("preemptive_priority_scheduler: match");
        else
            $display("preemptive_priority_scheduler: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pps_pkg.sv
sv/pps_table.sv
sv/preemptive_priority_scheduler.sv
verif/preemptive_priority_scheduler_test.sv
